// File: rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Types and constants shared by the color sort conveyor controller.
// ----------------------------------------------------------------------------
package csc_pkg;

  typedef enum logic [2:0] {
    MODE_CONTROL   = 3'd0,
    MODE_REJ_RED   = 3'd1,
    MODE_REJ_BLUE  = 3'd2,
    MODE_STOP_RED  = 3'd3,
    MODE_STOP_BLUE = 3'd4,
    MODE_DELAY_OFF = 3'd5,
    MODE_DELAY_ON  = 3'd6,
    MODE_ANTI_JAM  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_OPERATOR = 2'd1,
    ACT_MODE_REQ = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_CONTINUOUS  = 3'd0,
    REG_JAM_ENABLE  = 3'd1,
    REG_COLOR_THR   = 3'd2,
    REG_REJ_OFF_DLY = 3'd3,
    REG_REJ_ON_DLY  = 3'd4,
    REG_JAM_REVERSE = 3'd5,
    REG_JAM_DETECT  = 3'd6,
    REG_JAM_CMD_THR = 3'd7
  } reg_idx_t;

  localparam int CFG_DATA_W = 12;
  localparam int MS_W       = 12;
  localparam int ELAPSED_W  = 10;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [7:0] DRIVE_FWD = 8'sd100;
  localparam logic signed [7:0] DRIVE_REV = -8'sd100;
  localparam logic signed [7:0] DRIVE_OFF = 8'sd0;
  localparam logic signed [7:0] VEL_STALL = 8'sd5;

  typedef struct packed {
    logic            continuous_sorting;
    logic            anti_jam_enable;
    logic [7:0]      color_threshold;
    logic [MS_W-1:0] reject_off_delay_ms;
    logic [MS_W-1:0] reject_on_delay_ms;
    logic [MS_W-1:0] jam_reverse_ms;
    logic [MS_W-1:0] jam_detect_ms;
    logic [6:0]      jam_cmd_threshold;
  } cfg_t;

  typedef struct packed {
    action_t                action;
    logic [ELAPSED_W-1:0]   elapsed_ms;
    logic [7:0]             red_level;
    logic [7:0]             blue_level;
    logic                   near_object;
    logic signed [7:0]      hook_velocity_pct;
    logic signed [7:0]      operator_cmd;
    mode_t                  requested_mode;
  } item_t;

  typedef struct packed {
    logic signed [7:0] hook_cmd;
    logic signed [7:0] intake_cmd;
    logic              light_on;
    mode_t             mode_now;
  } result_t;

endpackage

// File: rtl/csc_cfg.sv
// ----------------------------------------------------------------------------
// csc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module csc_cfg import csc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.continuous_sorting  <= 1'b0;
      cfg.anti_jam_enable     <= 1'b0;
      cfg.color_threshold     <= 8'd75;
      cfg.reject_off_delay_ms <= 12'd170;
      cfg.reject_on_delay_ms  <= 12'd250;
      cfg.jam_reverse_ms      <= 12'd250;
      cfg.jam_detect_ms       <= 12'd125;
      cfg.jam_cmd_threshold   <= 7'd50;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CONTINUOUS:  cfg.continuous_sorting  <= cfg_wdata[0];
        REG_JAM_ENABLE:  cfg.anti_jam_enable     <= cfg_wdata[0];
        REG_COLOR_THR:   cfg.color_threshold     <= cfg_wdata[7:0];
        REG_REJ_OFF_DLY: cfg.reject_off_delay_ms <= cfg_wdata[MS_W-1:0];
        REG_REJ_ON_DLY:  cfg.reject_on_delay_ms  <= cfg_wdata[MS_W-1:0];
        REG_JAM_REVERSE: cfg.jam_reverse_ms      <= cfg_wdata[MS_W-1:0];
        REG_JAM_DETECT:  cfg.jam_detect_ms       <= cfg_wdata[MS_W-1:0];
        REG_JAM_CMD_THR: cfg.jam_cmd_threshold   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/csc_core.sv
// ----------------------------------------------------------------------------
// csc_core
// Controller state and its one-item update: timers, mode machine, jam check.
// ----------------------------------------------------------------------------
module csc_core import csc_pkg::*; #(
  parameter int TIMER_BITS = 13
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step_en,
  input  item_t   item,
  output result_t result
);

  localparam int CW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
  localparam logic [TIMER_BITS:0] TMAX = {1'b0, {TIMER_BITS{1'b1}}};

  mode_t                  mode, mode_next;
  mode_t                  prev_mode, prev_mode_next;
  logic signed [7:0]      hook_drive, hook_drive_next;
  logic signed [7:0]      intake_drive, intake_drive_next;
  logic signed [7:0]      held_cmd, held_cmd_next;
  logic [MS_W-1:0]        delay_target, delay_target_next;
  logic [TIMER_BITS-1:0]  delay_timer, delay_timer_next;
  logic [TIMER_BITS-1:0]  moving_timer, moving_timer_next;
  logic                   light_reg, light_next;

  logic [TIMER_BITS:0]    dsum, msum;
  logic [TIMER_BITS-1:0]  dt, mt;
  logic                   red_hit, blue_hit, passed;
  logic signed [7:0]      op_clamped;

  always_comb begin
    dsum = {1'b0, delay_timer} + (TIMER_BITS+1)'(item.elapsed_ms);
    msum = {1'b0, moving_timer} + (TIMER_BITS+1)'(item.elapsed_ms);
    dt   = (dsum > TMAX) ? TMAX[TIMER_BITS-1:0] : dsum[TIMER_BITS-1:0];
    mt   = (msum > TMAX) ? TMAX[TIMER_BITS-1:0] : msum[TIMER_BITS-1:0];

    red_hit  = (item.red_level > cfg.color_threshold)
            && (item.blue_level < cfg.color_threshold);
    blue_hit = (item.blue_level > cfg.color_threshold)
            && (item.red_level < cfg.color_threshold);
    passed   = CW'(dt) > CW'(delay_target);

    if (item.operator_cmd > DRIVE_FWD)      op_clamped = DRIVE_FWD;
    else if (item.operator_cmd < DRIVE_REV) op_clamped = DRIVE_REV;
    else                                    op_clamped = item.operator_cmd;

    mode_next         = mode;
    prev_mode_next    = prev_mode;
    hook_drive_next   = hook_drive;
    intake_drive_next = intake_drive;
    held_cmd_next     = held_cmd;
    delay_target_next = delay_target;
    delay_timer_next  = dt;
    moving_timer_next = mt;
    light_next        = light_reg;

    unique case (item.action)
      ACT_TICK: begin
        unique case (mode)
          MODE_CONTROL: begin
            hook_drive_next   = held_cmd;
            intake_drive_next = held_cmd;
            light_next        = 1'b0;
          end
          MODE_REJ_RED, MODE_REJ_BLUE: begin
            hook_drive_next   = DRIVE_FWD;
            intake_drive_next = DRIVE_FWD;
            light_next        = 1'b1;
            if ((mode == MODE_REJ_RED) ? red_hit : blue_hit) begin
              prev_mode_next    = mode;
              moving_timer_next = '0;
              mode_next         = MODE_DELAY_OFF;
              light_next        = 1'b0;
              delay_target_next = cfg.reject_off_delay_ms;
              delay_timer_next  = '0;
            end
          end
          MODE_STOP_RED, MODE_STOP_BLUE: begin
            hook_drive_next   = DRIVE_FWD;
            intake_drive_next = DRIVE_FWD;
            light_next        = 1'b1;
            if (((mode == MODE_STOP_RED) ? red_hit : blue_hit) || item.near_object) begin
              hook_drive_next   = DRIVE_OFF;
              held_cmd_next     = DRIVE_OFF;
              prev_mode_next    = mode;
              moving_timer_next = '0;
              mode_next         = MODE_CONTROL;
              light_next        = 1'b0;
            end
          end
          MODE_DELAY_OFF: begin
            if (passed) begin
              hook_drive_next   = DRIVE_OFF;
              intake_drive_next = DRIVE_OFF;
              moving_timer_next = '0;
              if (cfg.continuous_sorting) begin
                // back-to-back mode switches leave previous_mode unchanged
                mode_next         = MODE_DELAY_ON;
                delay_target_next = cfg.reject_on_delay_ms;
                delay_timer_next  = '0;
              end else begin
                prev_mode_next = mode;
                mode_next      = MODE_CONTROL;
              end
            end else begin
              hook_drive_next   = DRIVE_FWD;
              intake_drive_next = DRIVE_FWD;
            end
          end
          MODE_DELAY_ON: begin
            if (passed) begin
              hook_drive_next   = DRIVE_FWD;
              intake_drive_next = DRIVE_FWD;
              prev_mode_next    = mode;
              moving_timer_next = '0;
              mode_next         = cfg.continuous_sorting ? prev_mode : MODE_CONTROL;
            end else begin
              hook_drive_next   = DRIVE_OFF;
              intake_drive_next = DRIVE_OFF;
            end
          end
          MODE_ANTI_JAM: begin
            if (passed) begin
              hook_drive_next   = DRIVE_FWD;
              prev_mode_next    = mode;
              moving_timer_next = '0;
              mode_next         = prev_mode;
            end else begin
              hook_drive_next = DRIVE_REV;
            end
          end
        endcase

        // jam check uses the hook command latched before this tick
        if ((hook_drive > $signed({1'b0, cfg.jam_cmd_threshold}))
            && (item.hook_velocity_pct < VEL_STALL)
            && (mode_next != MODE_ANTI_JAM)) begin
          if (cfg.anti_jam_enable
              && (CW'(moving_timer_next) > CW'(cfg.jam_detect_ms))) begin
            delay_target_next = cfg.jam_reverse_ms;
            delay_timer_next  = '0;
            prev_mode_next    = mode_next;
            mode_next         = MODE_ANTI_JAM;
          end
        end else begin
          moving_timer_next = '0;
        end
      end
      ACT_OPERATOR: begin
        if (op_clamped != held_cmd) begin
          moving_timer_next = '0;
          held_cmd_next     = op_clamped;
        end
      end
      ACT_MODE_REQ: begin
        prev_mode_next    = mode;
        moving_timer_next = '0;
        mode_next         = item.requested_mode;
      end
      default: ;
    endcase

    result.hook_cmd   = hook_drive_next;
    result.intake_cmd = intake_drive_next;
    result.light_on   = light_next;
    result.mode_now   = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_CONTROL;
      prev_mode    <= MODE_CONTROL;
      hook_drive   <= DRIVE_OFF;
      intake_drive <= DRIVE_OFF;
      held_cmd     <= DRIVE_OFF;
      delay_target <= '0;
      delay_timer  <= '0;
      moving_timer <= '0;
      light_reg    <= 1'b0;
    end else if (step_en) begin
      mode         <= mode_next;
      prev_mode    <= prev_mode_next;
      hook_drive   <= hook_drive_next;
      intake_drive <= intake_drive_next;
      held_cmd     <= held_cmd_next;
      delay_target <= delay_target_next;
      delay_timer  <= delay_timer_next;
      moving_timer <= moving_timer_next;
      light_reg    <= light_next;
    end
  end

endmodule

// File: rtl/color_sort_conveyor_controller.sv
// ----------------------------------------------------------------------------
// color_sort_conveyor_controller
// Hook and intake motor controller with color sorting and anti-jam reverse.
// ----------------------------------------------------------------------------
// Flow: an accepted item is held in the input register; the state update and
// the result register take it together once the output side is not stalled.
// Throughput: one item per cycle while the output is not stalled; the state update is a single step.
// Reset (rst, synchronous): state cleared, registers to defaults, both
// stream sides empty.
module color_sort_conveyor_controller import csc_pkg::*; #(
  parameter int TIMER_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // elapsed_ms[9:0], red_level[17:10], blue_level[25:18], near_object[26],
  // hook_velocity_pct[34:27], operator_cmd[42:35], requested_mode[45:43]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hook_cmd[7:0], intake_cmd[15:8], light_on[16], mode_now[19:17]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_r;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  csc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  csc_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (advance),
    .item    (item_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (s_axis_tready && s_axis_tvalid) begin
      item_r.action            <= action_t'(s_axis_tuser);
      item_r.elapsed_ms        <= s_axis_tdata[9:0];
      item_r.red_level         <= s_axis_tdata[17:10];
      item_r.blue_level        <= s_axis_tdata[25:18];
      item_r.near_object       <= s_axis_tdata[26];
      item_r.hook_velocity_pct <= s_axis_tdata[34:27];
      item_r.operator_cmd      <= s_axis_tdata[42:35];
      item_r.requested_mode    <= mode_t'(s_axis_tdata[45:43]);
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign m_axis_tdata = {4'd0, out_r.mode_now, out_r.light_on,
                         out_r.intake_cmd, out_r.hook_cmd};

endmodule

// File: rtl/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the color sort conveyor controller.
// ----------------------------------------------------------------------------
module csc_checker import csc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // no result may appear right out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_hook_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) >= DRIVE_REV)
                   && ($signed(m_axis_tdata[7:0]) <= DRIVE_FWD))
    else $error("hook command out of range");

  a_intake_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:8]) >= DRIVE_REV)
                   && ($signed(m_axis_tdata[15:8]) <= DRIVE_FWD))
    else $error("intake command out of range");

endmodule

bind color_sort_conveyor_controller csc_checker u_csc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/color_sort_conveyor_controller_tb.sv
// ----------------------------------------------------------------------------
// color_sort_conveyor_controller_tb
// Stream-level test of the conveyor controller. Ticks, operator commands and
// mode requests are sent in random bursts, and a cycle-free model of the mode
// machine, timers and jam check predicts each drive result. Results are
// checked in order. Settings are changed between phases while the block idles.
// ----------------------------------------------------------------------------
module color_sort_conveyor_controller_tb;
  import csc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_BITS = 13;
  localparam int TIMER_MAX  = (1 << TIMER_BITS) - 1;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 110;
  localparam action_t ACT_SPARE = action_t'(2'd3);

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  color_sort_conveyor_controller #(.TIMER_BITS(TIMER_BITS)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drive model state
  // --------------------------------------------------------------------------
  cfg_t cfg_cur = '{continuous_sorting: 1'b0, anti_jam_enable: 1'b0,
                    color_threshold: 8'd75, reject_off_delay_ms: 12'd170,
                    reject_on_delay_ms: 12'd250, jam_reverse_ms: 12'd250,
                    jam_detect_ms: 12'd125, jam_cmd_threshold: 7'd50};

  mode_t                 cur_mode   = MODE_CONTROL;
  mode_t                 saved_mode = MODE_CONTROL;
  logic signed [7:0]     hook_drv   = DRIVE_OFF;
  logic signed [7:0]     intake_drv = DRIVE_OFF;
  logic signed [7:0]     held_cmd   = DRIVE_OFF;
  logic [MS_W-1:0]       dly_target = '0;
  logic [TIMER_BITS-1:0] dly_timer  = '0;
  logic [TIMER_BITS-1:0] move_timer = '0;
  logic                  light      = 1'b0;

  item_t   items_to_send[$];
  result_t expected_drive_q[$];
  int      errors = 0;
  int      results_seen = 0;
  int      last_cmd_sent = 0;

  function automatic logic [TIMER_BITS-1:0] sat_add(logic [TIMER_BITS-1:0] t,
                                                    logic [ELAPSED_W-1:0] d);
    int s;
    s = int'(t) + int'(d);
    return (s > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0] : s[TIMER_BITS-1:0];
  endfunction

  function automatic void enter_mode(mode_t m);
    saved_mode = cur_mode;
    move_timer = '0;
    cur_mode   = m;
  endfunction

  // One item through the mode machine; returns the registered drive outputs.
  function automatic result_t conveyor_step(item_t it);
    result_t r;
    int      prior_hook, vel, cmd;
    logic    red_hit, blue_hit, passed;
    dly_timer = sat_add(dly_timer, it.elapsed_ms);
    move_timer = sat_add(move_timer, it.elapsed_ms);
    case (it.action)
      ACT_TICK: begin
        prior_hook = hook_drv;
        vel = $signed(it.hook_velocity_pct);
        red_hit = it.red_level > cfg_cur.color_threshold &&
                  it.blue_level < cfg_cur.color_threshold;
        blue_hit = it.blue_level > cfg_cur.color_threshold &&
                   it.red_level < cfg_cur.color_threshold;
        passed = dly_timer > dly_target;
        case (cur_mode)
          MODE_CONTROL: begin
            hook_drv = held_cmd;
            intake_drv = held_cmd;
            light = 1'b0;
          end
          MODE_REJ_RED, MODE_REJ_BLUE: begin
            hook_drv = DRIVE_FWD;
            intake_drv = DRIVE_FWD;
            light = 1'b1;
            if (cur_mode == MODE_REJ_RED ? red_hit : blue_hit) begin
              enter_mode(MODE_DELAY_OFF);
              light = 1'b0;
              dly_target = cfg_cur.reject_off_delay_ms;
              dly_timer = '0;
            end
          end
          MODE_STOP_RED, MODE_STOP_BLUE: begin
            hook_drv = DRIVE_FWD;
            intake_drv = DRIVE_FWD;
            light = 1'b1;
            if ((cur_mode == MODE_STOP_RED ? red_hit : blue_hit) || it.near_object) begin
              hook_drv = DRIVE_OFF;
              held_cmd = DRIVE_OFF;
              enter_mode(MODE_CONTROL);
              light = 1'b0;
            end
          end
          MODE_DELAY_OFF: begin
            if (passed) begin
              hook_drv = DRIVE_OFF;
              intake_drv = DRIVE_OFF;
              if (cfg_cur.continuous_sorting) begin
                enter_mode(saved_mode);
                enter_mode(MODE_DELAY_ON);
                dly_target = cfg_cur.reject_on_delay_ms;
                dly_timer = '0;
              end else begin
                enter_mode(MODE_CONTROL);
              end
            end else begin
              hook_drv = DRIVE_FWD;
              intake_drv = DRIVE_FWD;
            end
          end
          MODE_DELAY_ON: begin
            if (passed) begin
              hook_drv = DRIVE_FWD;
              intake_drv = DRIVE_FWD;
              enter_mode(cfg_cur.continuous_sorting ? saved_mode : MODE_CONTROL);
            end else begin
              hook_drv = DRIVE_OFF;
              intake_drv = DRIVE_OFF;
            end
          end
          default: begin
            // reverse drive only touches the hook motor
            if (passed) begin
              hook_drv = DRIVE_FWD;
              enter_mode(saved_mode);
            end else begin
              hook_drv = DRIVE_REV;
            end
          end
        endcase
        // jam check looks at the hook command from before this tick
        if (prior_hook > int'(cfg_cur.jam_cmd_threshold) && vel < int'(VEL_STALL) &&
            cur_mode != MODE_ANTI_JAM) begin
          if (cfg_cur.anti_jam_enable && move_timer > cfg_cur.jam_detect_ms) begin
            dly_target = cfg_cur.jam_reverse_ms;
            dly_timer = '0;
            saved_mode = cur_mode;
            cur_mode = MODE_ANTI_JAM;
          end
        end else begin
          move_timer = '0;
        end
      end
      ACT_OPERATOR: begin
        cmd = $signed(it.operator_cmd);
        if (cmd > int'(DRIVE_FWD)) cmd = DRIVE_FWD;
        if (cmd < int'(DRIVE_REV)) cmd = DRIVE_REV;
        if (cmd != int'(held_cmd)) begin
          move_timer = '0;
          held_cmd = cmd[7:0];
        end
      end
      ACT_MODE_REQ: enter_mode(it.requested_mode);
      default: ;
    endcase
    r.hook_cmd = hook_drv;
    r.intake_cmd = intake_drv;
    r.light_on = light;
    r.mode_now = cur_mode;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic item_t noise_item();
    item_t it;
    it.action = action_t'($urandom_range(0, 3));
    it.elapsed_ms = ELAPSED_W'($urandom_range(0, 1023));
    it.red_level = 8'($urandom_range(0, 255));
    it.blue_level = 8'($urandom_range(0, 255));
    it.near_object = 1'($urandom_range(0, 1));
    it.hook_velocity_pct = 8'($urandom_range(0, 255));
    it.operator_cmd = 8'($urandom_range(0, 255));
    it.requested_mode = mode_t'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic int rnd_elapsed();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return 1023;
      2, 3, 4: return $urandom_range(0, 1023);
      default: return $urandom_range(1, 80);
    endcase
  endfunction

  task automatic push_tick(int el, int red, int blue, int near, int vel);
    item_t it;
    it = noise_item();
    it.action = ACT_TICK;
    it.elapsed_ms = el[ELAPSED_W-1:0];
    it.red_level = red[7:0];
    it.blue_level = blue[7:0];
    it.near_object = near[0];
    it.hook_velocity_pct = vel[7:0];
    items_to_send.push_back(it);
  endtask

  task automatic push_cmd(int el, int cmd);
    item_t it;
    it = noise_item();
    it.action = ACT_OPERATOR;
    it.elapsed_ms = el[ELAPSED_W-1:0];
    it.operator_cmd = cmd[7:0];
    last_cmd_sent = cmd;
    items_to_send.push_back(it);
  endtask

  task automatic push_mode(int el, mode_t m);
    item_t it;
    it = noise_item();
    it.action = ACT_MODE_REQ;
    it.elapsed_ms = el[ELAPSED_W-1:0];
    it.requested_mode = m;
    items_to_send.push_back(it);
  endtask

  task automatic push_rnd_tick();
    int thr, hi, lo, red, blue, vel;
    thr = cfg_cur.color_threshold;
    hi = (thr == 255) ? 255 : $urandom_range(thr + 1, 255);
    lo = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
    case ($urandom_range(0, 9))
      0: begin red = hi; blue = lo; end
      1: begin red = lo; blue = hi; end
      2: begin red = thr; blue = lo; end
      3: begin red = hi; blue = thr; end
      4: begin red = $urandom_range(0, 255); blue = $urandom_range(0, 255); end
      default: begin red = $urandom_range(0, thr); blue = $urandom_range(0, thr); end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: vel = $urandom_range(0, 9) - 5;   // stalled, up to 4
      5: vel = 5;
      6, 7: vel = $urandom_range(5, 100);
      8: vel = $urandom_range(0, 1) ? 100 : -100;
      default: vel = $urandom_range(0, 255) - 128;
    endcase
    push_tick(rnd_elapsed(), red, blue, ($urandom_range(0, 9) == 0), vel);
  endtask

  function automatic int rnd_cmd();
    case ($urandom_range(0, 4))
      0: return ($urandom_range(0, 2) - 1) * 100;
      1: return $urandom_range(0, 255) - 128;
      2: return last_cmd_sent;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  // A mode entry or command followed by a run of ticks, or a little noise.
  task automatic push_scenario();
    int n;
    n = $urandom_range(2, 14);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_mode(rnd_elapsed(),
                            mode_t'($urandom_range(MODE_REJ_RED, MODE_STOP_BLUE)));
      4: push_mode(rnd_elapsed(), mode_t'($urandom_range(MODE_DELAY_OFF, MODE_ANTI_JAM)));
      5: push_mode(rnd_elapsed(), MODE_CONTROL);
      6, 7: push_cmd(rnd_elapsed(), rnd_cmd());
      default: begin
        repeat ($urandom_range(1, 3)) items_to_send.push_back(noise_item());
        n = $urandom_range(0, 2);
      end
    endcase
    repeat (n) push_rnd_tick();
  endtask

  function automatic cfg_t rand_settings();
    cfg_t c;
    c.continuous_sorting = 1'($urandom_range(0, 1));
    c.anti_jam_enable = ($urandom_range(0, 3) != 0);
    c.color_threshold = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(30, 220));
    c.reject_off_delay_ms = MS_W'($urandom_range(0, 400));
    c.reject_on_delay_ms = MS_W'($urandom_range(0, 400));
    c.jam_reverse_ms = ($urandom_range(0, 5) == 0) ? MS_W'($urandom_range(0, 4095))
                                                   : MS_W'($urandom_range(0, 400));
    c.jam_detect_ms = MS_W'($urandom_range(0, 300));
    c.jam_cmd_threshold = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                      : 7'($urandom_range(0, 100));
    return c;
  endfunction

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
  endtask

  task automatic load_settings(cfg_t c);
    cfg_cur = c;
    write_reg(REG_CONTINUOUS, c.continuous_sorting);
    write_reg(REG_JAM_ENABLE, c.anti_jam_enable);
    write_reg(REG_COLOR_THR, c.color_threshold);
    write_reg(REG_REJ_OFF_DLY, c.reject_off_delay_ms);
    write_reg(REG_REJ_ON_DLY, c.reject_on_delay_ms);
    write_reg(REG_JAM_REVERSE, c.jam_reverse_ms);
    write_reg(REG_JAM_DETECT, c.jam_detect_ms);
    write_reg(REG_JAM_CMD_THR, c.jam_cmd_threshold);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // look just after the falling edge, once the driver has settled
  task automatic wait_drained();
    while (items_to_send.size() != 0 || s_axis_tvalid || expected_drive_q.size() != 0)
    begin
      @(negedge clk);
      #1;
    end
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   start;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed pass on reset settings
    push_tick(0, 0, 0, 0, 0);
    push_cmd(1023, -128);                  // clamps to full reverse
    push_cmd(5, -128);                     // same command, ignored
    push_tick(10, 75, 75, 0, -128);
    push_cmd(0, 127);
    push_tick(0, 255, 255, 1, 127);
    push_mode(0, MODE_REJ_RED);
    push_tick(20, 75, 75, 0, 0);           // level equal to threshold: no hit
    push_tick(20, 255, 0, 0, 50);          // red hit
    push_tick(170, 0, 0, 0, 50);           // timer equals target: still running
    push_tick(1, 0, 0, 0, 50);
    push_mode(0, MODE_REJ_BLUE);
    push_tick(3, 0, 255, 0, 0);
    push_tick(1023, 0, 0, 0, 0);
    push_mode(0, MODE_STOP_RED);
    push_tick(5, 0, 0, 1, 0);              // proximity stop
    push_mode(0, MODE_STOP_BLUE);
    push_tick(5, 74, 255, 0, 0);
    push_mode(0, MODE_DELAY_ON);
    push_tick(1023, 0, 0, 0, 0);
    push_mode(0, MODE_ANTI_JAM);
    push_tick(0, 0, 0, 0, 0);
    push_mode(0, MODE_DELAY_OFF);
    push_tick(1023, 0, 0, 0, 0);
    begin
      item_t spare;
      spare = noise_item();
      spare.action = ACT_SPARE;
      items_to_send.push_back(spare);
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c = '{continuous_sorting: 1'b1, anti_jam_enable: 1'b1, color_threshold: 8'hFF,
              reject_off_delay_ms: 12'hFFF, reject_on_delay_ms: 12'hFFF,
              jam_reverse_ms: 12'hFFF, jam_detect_ms: 12'hFFF, jam_cmd_threshold: 7'h7F};
      end else begin
        c = rand_settings();
      end
      load_settings(c);
      start = items_to_send.size();
      while (items_to_send.size() - start < PHASE_LEN) push_scenario();
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (expected_drive_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input driver: bursts with random gaps
  // --------------------------------------------------------------------------
  logic  in_fire = 1'b0;
  item_t send_item;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (items_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        send_item = items_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= send_item.action;
        s_axis_tdata <= {2'b00, send_item.requested_mode, send_item.operator_cmd,
                         send_item.hook_velocity_pct, send_item.near_object,
                         send_item.blue_level, send_item.red_level, send_item.elapsed_ms};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: stretches of different stall styles plus two long hold-offs
  // --------------------------------------------------------------------------
  int rx_hold = 0;
  int rx_span = 0;
  int rx_style = 0;
  int rx_count = 0;
  bit first_hold_done = 1'b0;
  bit second_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!first_hold_done && results_seen >= 320 && items_to_send.size() > 16) begin
      rx_hold = 80;
      first_hold_done = 1'b1;
    end else if (!second_hold_done && results_seen >= 700 && items_to_send.size() > 16) begin
      rx_hold = 80;
      second_hold_done = 1'b1;
    end
    if (rx_span == 0) begin
      rx_span = $urandom_range(16, 128);
      rx_style = $urandom_range(0, 3);
    end
    rx_span--;
    rx_count++;
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 4) != 0);
        default: m_axis_tready <= (rx_count % 3 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input transactions, check output transactions
  // --------------------------------------------------------------------------
  item_t   seen_item;
  result_t want, got;

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.hook_cmd = m_axis_tdata[7:0];
        got.intake_cmd = m_axis_tdata[15:8];
        got.light_on = m_axis_tdata[16];
        got.mode_now = mode_t'(m_axis_tdata[19:17]);
        if (expected_drive_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: hook=%0d intake=%0d light=%0b mode=%0d",
                     got.hook_cmd, got.intake_cmd, got.light_on, got.mode_now);
        end else begin
          want = expected_drive_q.pop_front();
          if (got.hook_cmd !== want.hook_cmd || got.intake_cmd !== want.intake_cmd ||
              got.light_on !== want.light_on || got.mode_now !== want.mode_now) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: exp hook=%0d intake=%0d light=%0b mode=%0d",
                       $realtime, want.hook_cmd, want.intake_cmd, want.light_on,
                       want.mode_now);
              $display("  got hook=%0d intake=%0d light=%0b mode=%0d",
                       got.hook_cmd, got.intake_cmd, got.light_on, got.mode_now);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.action = action_t'(s_axis_tuser);
        seen_item.elapsed_ms = s_axis_tdata[9:0];
        seen_item.red_level = s_axis_tdata[17:10];
        seen_item.blue_level = s_axis_tdata[25:18];
        seen_item.near_object = s_axis_tdata[26];
        seen_item.hook_velocity_pct = s_axis_tdata[34:27];
        seen_item.operator_cmd = s_axis_tdata[42:35];
        seen_item.requested_mode = mode_t'(s_axis_tdata[45:43]);
        expected_drive_q.push_back(conveyor_step(seen_item));
      end
    end
  end

endmodule
